/* rtl/gcd_lcm_unit_core_assert.svh */
// Assertion macros shared by the gcd/lcm unit.
`ifndef GCD_LCM_UNIT_CORE_ASSERT_SVH
`define GCD_LCM_UNIT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define GLU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gcd_lcm_unit assertion failed");
`define GLU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcd_lcm_unit assertion failed");
`else
`define GLU_ASSERT(lbl, clk, rst, prop)
`define GLU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/gcdlcm_pkg.sv */
package gcdlcm_pkg;

  localparam int OPERAND_BITS = 31;

  localparam int VAL_W       = 31;
  localparam int MUL_W       = 62;
  localparam int SHIFT_W     = 5;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 96;

  localparam logic [VAL_W-1:0] OPER_MASK = (OPERAND_BITS >= VAL_W) ? {VAL_W{1'b1}} :
                                           VAL_W'((64'd1 << OPERAND_BITS) - 64'd1);

  localparam logic [SHIFT_W-1:0] DIV_LAST_CNT = SHIFT_W'(VAL_W - 1);

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic form_g;
    logic div_step;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic zero_in;
    logic gcd_equal;
    logic div_last;
  } status_t;

endpackage

/* rtl/gcd_lcm_unit_core.sv */
// GCD / LCM unit.
// Input stream s_*: one transaction carries two operands; s_tready is high
// only while the unit is idle. Output stream m_*: one transaction per input
// with the gcd, the lcm and a zero-operand flag in m_tuser (gcd and lcm are
// zero when the flag is set).
// Steps in order: gcd by binary subtract-and-shift (each step removes at
// least one operand bit), then rescaling of the gcd, the bit-serial divider
// for b / gcd, the 31x31 multiplier and the load of the output register. A
// zero operand skips all arithmetic and goes straight to the output load.
// The result sits in an output register; while the receiver stalls the unit
// accepts and works on the next transaction and holds it until the output
// register frees. Synchronous reset returns to idle and drops any pending
// result; no state is kept between transactions.
module gcd_lcm_unit_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // first_value [30:0], second_value [61:31], zeros above
  input  logic [gcdlcm_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // divisor_out [30:0], multiple_out [92:31], zeros above
  output logic [gcdlcm_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // zero_error [0]
  output logic                                m_tuser
);

  gcdlcm_pkg::cmd_t                cmd;
  gcdlcm_pkg::status_t             status;
  logic [gcdlcm_pkg::VAL_W-1:0]    divisor_out;
  logic [gcdlcm_pkg::MUL_W-1:0]    multiple_out;

  gcdlcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gcdlcm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .first_value  (s_tdata[gcdlcm_pkg::VAL_W-1:0]),
    .second_value (s_tdata[2*gcdlcm_pkg::VAL_W-1:gcdlcm_pkg::VAL_W]),
    .divisor_out  (divisor_out),
    .multiple_out (multiple_out),
    .zero_error   (m_tuser)
  );

  assign m_tdata = {{(gcdlcm_pkg::OUT_TDATA_W - gcdlcm_pkg::VAL_W - gcdlcm_pkg::MUL_W){1'b0}},
                    multiple_out, divisor_out};

endmodule

/* rtl/gcdlcm_dp.sv */
`include "gcd_lcm_unit_core_assert.svh"

module gcdlcm_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  gcdlcm_pkg::cmd_t                cmd,
  output gcdlcm_pkg::status_t             status,
  input  logic [gcdlcm_pkg::VAL_W-1:0]    first_value,
  input  logic [gcdlcm_pkg::VAL_W-1:0]    second_value,
  output logic [gcdlcm_pkg::VAL_W-1:0]    divisor_out,
  output logic [gcdlcm_pkg::MUL_W-1:0]    multiple_out,
  output logic                            zero_error
);

  logic [gcdlcm_pkg::VAL_W-1:0]   a_in;
  logic [gcdlcm_pkg::VAL_W-1:0]   b_in;
  logic [gcdlcm_pkg::VAL_W-1:0]   a_reg;
  logic [gcdlcm_pkg::VAL_W-1:0]   b_reg;
  logic                           err;
  logic [gcdlcm_pkg::VAL_W-1:0]   u;
  logic [gcdlcm_pkg::VAL_W-1:0]   v;
  logic [gcdlcm_pkg::SHIFT_W-1:0] k;
  logic [gcdlcm_pkg::VAL_W-1:0]   g;
  logic [gcdlcm_pkg::VAL_W-1:0]   rem;
  logic [gcdlcm_pkg::VAL_W-1:0]   quot;
  logic [gcdlcm_pkg::SHIFT_W-1:0] cnt;
  logic [gcdlcm_pkg::MUL_W-1:0]   prod;
  logic [gcdlcm_pkg::VAL_W:0]     rem_shift;
  logic                           rem_ge;
  logic [gcdlcm_pkg::VAL_W-1:0]   rem_next;

  assign a_in = first_value & gcdlcm_pkg::OPER_MASK;
  assign b_in = second_value & gcdlcm_pkg::OPER_MASK;

  assign status.zero_in   = (a_in == '0) || (b_in == '0);
  assign status.gcd_equal = (u == v);
  assign status.div_last  = (cnt == '0);

  // restoring division of b by g, one quotient bit per cycle
  assign rem_shift = {rem, quot[gcdlcm_pkg::VAL_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, g});
  assign rem_next  = rem_ge ? gcdlcm_pkg::VAL_W'(rem_shift - {1'b0, g})
                            : gcdlcm_pkg::VAL_W'(rem_shift);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg <= a_in;
      b_reg <= b_in;
      err   <= status.zero_in;
      u     <= a_in;
      v     <= b_in;
      k     <= '0;
    end
    if (cmd.gcd_step) begin
      // binary gcd: strip common twos (counted in k), then halve an even value or the difference of odd values
      case ({u[0], v[0]})
        2'b00: begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end
        2'b01: u <= u >> 1;
        2'b10: v <= v >> 1;
        default: begin
          if (u > v) begin
            u <= (u - v) >> 1;
          end else begin
            v <= (v - u) >> 1;
          end
        end
      endcase
    end
    if (cmd.form_g) begin
      g    <= u << k;
      rem  <= '0;
      quot <= b_reg;
      cnt  <= gcdlcm_pkg::DIV_LAST_CNT;
    end
    if (cmd.div_step) begin
      rem  <= rem_next;
      quot <= {quot[gcdlcm_pkg::VAL_W-2:0], rem_ge};
      cnt  <= cnt - 1'b1;
    end
    if (cmd.mul) begin
      prod <= gcdlcm_pkg::MUL_W'(a_reg) * gcdlcm_pkg::MUL_W'(quot);
    end
    if (cmd.out_load) begin
      divisor_out  <= err ? '0 : g;
      multiple_out <= err ? '0 : prod;
      zero_error   <= err;
    end
  end

  `GLU_ASSERT(a_gcd_nonzero, clk, rst, cmd.gcd_step |-> (u != '0) && (v != '0))
  `GLU_ASSERT_NEXT(a_div_exact, clk, rst, cmd.div_step && status.div_last, rem == '0)

endmodule

/* rtl/gcdlcm_ctrl.sv */
`include "gcd_lcm_unit_core_assert.svh"

module gcdlcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  gcdlcm_pkg::status_t status,
  output gcdlcm_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = status.zero_in ? ST_OUT : ST_GCD;
        end
      end
      ST_GCD: begin
        if (status.gcd_equal) begin
          cmd.form_g = 1'b1;
          state_next = ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `GLU_ASSERT(a_one_cmd, clk, rst,
              $onehot0({cmd.load, cmd.gcd_step, cmd.form_g, cmd.div_step, cmd.mul, cmd.out_load}))
  `GLU_ASSERT_NEXT(a_out_load, clk, rst, cmd.out_load, m_tvalid && (state == ST_IDLE))

endmodule

/* test/tb.sv */
module tb;
  import gcdlcm_pkg::*;

  localparam int NUM_RANDOM     = 1800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int MAX_GAP        = 10;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef struct {
    logic [VAL_W-1:0] divisor;
    logic [MUL_W-1:0] multiple;
    logic             zero_error;
  } gcd_lcm_result_t;

  class gcd_lcm_scoreboard;
    gcd_lcm_result_t expected_q[$];
    int errors;
    int checked;
    int zero_seen;
    int coprime_seen;

    function new();
      errors       = 0;
      checked      = 0;
      zero_seen    = 0;
      coprime_seen = 0;
    endfunction

    function gcd_lcm_result_t predict(logic [VAL_W-1:0] first, logic [VAL_W-1:0] second);
      gcd_lcm_result_t r;
      longint unsigned a, b, big, sml, rem, g, m;
      a = longint'(first & OPER_MASK);
      b = longint'(second & OPER_MASK);
      r.divisor    = '0;
      r.multiple   = '0;
      r.zero_error = 1'b1;
      if (a != 0 && b != 0) begin
        big = (a < b) ? b : a;
        sml = (a < b) ? a : b;
        g   = big;
        while (sml != 0) begin
          rem = big % sml;
          g   = sml;
          big = sml;
          sml = rem;
        end
        m = a * (b / g);
        r.divisor    = g[VAL_W-1:0];
        r.multiple   = m[MUL_W-1:0];
        r.zero_error = 1'b0;
      end
      return r;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task note(logic [VAL_W-1:0] first, logic [VAL_W-1:0] second);
      expected_q.push_back(predict(first, second));
    endtask

    task check(logic [VAL_W-1:0] divisor, logic [MUL_W-1:0] multiple, logic zero_error);
      gcd_lcm_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: gcd=%0d lcm=%0d zero=%0b",
                         divisor, multiple, zero_error));
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (e.zero_error) zero_seen++;
        else if (e.divisor == 1) coprime_seen++;
        if (divisor !== e.divisor)
          report($sformatf("gcd %0d, expected %0d", divisor, e.divisor));
        if (multiple !== e.multiple)
          report($sformatf("lcm %0d, expected %0d", multiple, e.multiple));
        if (zero_error !== e.zero_error)
          report($sformatf("zero flag %0b, expected %0b", zero_error, e.zero_error));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  bit no_gaps;
  int quiet_cycles;
  gcd_lcm_scoreboard sb;

  gcd_lcm_unit_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // valid stays high across back-to-back transactions
  task send_operands(logic [VAL_W-1:0] first, logic [VAL_W-1:0] second);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - 2 * VAL_W){1'b0}}, second, first};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function logic [VAL_W-1:0] rand_val();
    return VAL_W'($urandom());
  endfunction

  task send_random();
    int unsigned kind, g_bits;
    logic [VAL_W-1:0] a, b, g, t;
    longint unsigned p;
    kind = $urandom_range(0, 99);
    a = rand_val();
    b = rand_val();
    if (kind < 8) begin
      case ($urandom_range(0, 2))
        0: a = '0;
        1: b = '0;
        default: begin
          a = '0;
          b = '0;
        end
      endcase
    end else if (kind < 35) begin
      // shared factor of random size
      g_bits = $urandom_range(1, VAL_W - 1);
      g = VAL_W'($urandom_range(1, (32'd1 << g_bits) - 1));
      p = longint'(g) * $urandom_range(1, VAL_MAX / g);
      a = p[VAL_W-1:0];
      p = longint'(g) * $urandom_range(1, VAL_MAX / g);
      b = p[VAL_W-1:0];
    end else if (kind < 50) begin
      a = VAL_W'($urandom_range(1, 255));
      b = VAL_W'($urandom_range(1, 255));
    end else if (kind < 58) begin
      b = a + VAL_W'($urandom_range(0, 2)) - 1'b1;
    end else if (kind < 68) begin
      a = VAL_W'($urandom_range(1, 65535));
      p = longint'(a) * $urandom_range(1, VAL_MAX / a);
      b = p[VAL_W-1:0];
      if ($urandom_range(0, 1)) begin
        t = a;
        a = b;
        b = t;
      end
    end
    send_operands(a, b);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready)
        sb.note(s_tdata[VAL_W-1:0], s_tdata[2*VAL_W-1:VAL_W]);
      if (m_tvalid && m_tready)
        sb.check(m_tdata[VAL_W-1:0], m_tdata[VAL_W+MUL_W-1:VAL_W], m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin : watchdog
    @(posedge clk);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("gcd_lcm_unit_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    no_gaps = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero operands
    send_operands('0, '0);
    send_operands('0, VAL_MAX);
    send_operands(VAL_MAX, '0);
    send_operands('0, 31'd1);
    // extremes
    send_operands(31'd1, 31'd1);
    send_operands(VAL_MAX, VAL_MAX);
    send_operands(VAL_MAX, 31'd1);
    send_operands(31'd1, VAL_MAX);
    send_operands(VAL_MAX, VAL_MAX - 1'b1);
    send_operands(VAL_MAX - 1'b1, VAL_MAX);
    send_operands(31'h4000_0000, 31'h2000_0000);
    send_operands(31'h4000_0000, VAL_MAX);
    send_operands(31'h5555_5555, 31'h2AAA_AAAA);
    // longest Euclid chains: consecutive Fibonacci numbers
    send_operands(31'd1836311903, 31'd1134903170);
    send_operands(31'd1134903170, 31'd1836311903);
    // one divides the other, shared factors, coprime
    send_operands(31'd12, 31'd36);
    send_operands(31'd36, 31'd12);
    send_operands(31'd46340, 31'd46341);
    send_operands(31'd2147483646, 31'd1073741823);
    send_operands(31'd65536, 31'd32767);
    send_operands(31'd1000000007, 31'd999999937);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_random();
    end
    s_tvalid <= 1'b0;
    no_gaps = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results: %0d zero-operand, %0d coprime, %0d mismatches",
             sb.checked, sb.zero_seen, sb.coprime_seen, sb.errors);
    $display("operands spanned small, shared-factor, divisible and full-range pairs");
    if (sb.errors == 0)
      $display("gcd_lcm_unit_core regression: pass");
    else
      $display("gcd_lcm_unit_core regression: fail");
    $finish;
  end

endmodule
